@@ rtl/dpwp_pkg.sv @@
// Shared widths, register indexes and codes for the depth pixel to world point unit.
// Used by the top level and its port checker; no dependencies.
package dpwp_pkg;

	localparam int PIX_W   = 10;
	localparam int DEPTH_W = 16;
	localparam int FOC_W   = 24;
	localparam int ROT_W   = 16;
	localparam int OUT_W   = 24;
	localparam int APB_W   = 32;
	localparam int ADDR_W  = 5;

	localparam int DU_W    = PIX_W + 1;
	localparam int PU_W    = DU_W + DEPTH_W + 1;
	localparam int Q_W     = PU_W + FOC_W + 1;
	localparam int FOC_SH  = 24;
	localparam int CAM_W   = Q_W - FOC_SH;
	localparam int B_W     = CAM_W + 1;
	localparam int RP_W    = 2 * ROT_W;
	localparam int R_W     = 35;
	localparam int R_FRAC  = 28;
	localparam int LO_W    = 18;
	localparam int HI_W    = R_W - LO_W;
	localparam int PLO_W   = LO_W + 1 + B_W;
	localparam int PHI_W   = HI_W + B_W;
	localparam int P_W     = 64;
	localparam int S_W     = P_W + 2;
	localparam int RND_W   = S_W - R_FRAC;
	localparam int T_W     = RND_W + 1;

	localparam int LATENCY = 8;

	localparam logic [DEPTH_W-1:0] NO_RETURN = '1;
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic [FOC_W-1:0] FOCAL_RESET = 24'd156206;
	localparam logic [ROT_W-1:0] ROT_ONE     = 16'd16384;

	localparam logic [2:0] REG_INVERSE_FOCAL = 3'd0;
	localparam logic [2:0] REG_ROT_W         = 3'd1;
	localparam logic [2:0] REG_ROT_X         = 3'd2;
	localparam logic [2:0] REG_ROT_Y         = 3'd3;
	localparam logic [2:0] REG_ROT_Z         = 3'd4;
	localparam logic [2:0] REG_SHIFT_X       = 3'd5;
	localparam logic [2:0] REG_SHIFT_Y       = 3'd6;
	localparam logic [2:0] REG_SHIFT_Z       = 3'd7;

	typedef logic signed [OUT_W-1:0] coord_t;
	typedef logic signed [ROT_W-1:0] quat_t;

endpackage

@@ rtl/depth_pixel_to_world_point_unit.sv @@
// Depth pixel to world point: eight-stage pipeline from pixel to world coordinate.
// Valid bits v_s1 to v_s8 carry start to done; one word per cycle, busy stays low.
// Rotation matrix is rebuilt from the pose registers via product registers.
// arst_n clears the valid bits and loads the register reset values; no clearing pass.
// Depends on dpwp_pkg.
module depth_pixel_to_world_point_unit #(
	parameter int CENTER_X = 128,
	parameter int CENTER_Y = 72
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [dpwp_pkg::PIX_W-1:0]      column,
	input  logic [dpwp_pkg::PIX_W-1:0]      row,
	input  logic [dpwp_pkg::DEPTH_W-1:0]    depth_mm,
	output logic                            done,
	output dpwp_pkg::coord_t                world_x,
	output dpwp_pkg::coord_t                world_y,
	output dpwp_pkg::coord_t                world_z,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dpwp_pkg::ADDR_W-1:0]     paddr,
	input  logic [dpwp_pkg::APB_W-1:0]      pwdata,
	output logic [dpwp_pkg::APB_W-1:0]      prdata,
	output logic                            pready
);

	localparam int DU_W  = dpwp_pkg::DU_W;
	localparam int PU_W  = dpwp_pkg::PU_W;
	localparam int Q_W   = dpwp_pkg::Q_W;
	localparam int B_W   = dpwp_pkg::B_W;
	localparam int RP_W  = dpwp_pkg::RP_W;
	localparam int R_W   = dpwp_pkg::R_W;
	localparam int LO_W  = dpwp_pkg::LO_W;
	localparam int HI_W  = dpwp_pkg::HI_W;
	localparam int PLO_W = dpwp_pkg::PLO_W;
	localparam int PHI_W = dpwp_pkg::PHI_W;
	localparam int P_W   = dpwp_pkg::P_W;
	localparam int S_W   = dpwp_pkg::S_W;
	localparam int RND_W = dpwp_pkg::RND_W;
	localparam int T_W   = dpwp_pkg::T_W;
	localparam int FOC_SH = dpwp_pkg::FOC_SH;
	localparam int R_FRAC = dpwp_pkg::R_FRAC;
	localparam int OUT_W = dpwp_pkg::OUT_W;

	localparam logic signed [DU_W-1:0] CX = DU_W'(CENTER_X);
	localparam logic signed [DU_W-1:0] CY = DU_W'(CENTER_Y);
	localparam logic signed [Q_W-1:0]  Q_HALF = Q_W'(64'd1 << (FOC_SH - 1));
	localparam logic signed [S_W-1:0]  S_HALF = S_W'(64'd1 << (R_FRAC - 1));
	localparam logic signed [R_W-1:0]  R_ONE  = R_W'(64'd1 << R_FRAC);

	logic [dpwp_pkg::FOC_W-1:0]  inverse_focal_q;
	dpwp_pkg::quat_t             rot_w_q, rot_x_q, rot_y_q, rot_z_q;
	dpwp_pkg::coord_t            shift_q [3];

	logic                        cfg_wr;
	logic [2:0]                  cfg_idx;

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[dpwp_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_focal_q <= dpwp_pkg::FOCAL_RESET;
			rot_w_q         <= dpwp_pkg::ROT_ONE;
			rot_x_q         <= '0;
			rot_y_q         <= '0;
			rot_z_q         <= '0;
			shift_q[0]      <= '0;
			shift_q[1]      <= '0;
			shift_q[2]      <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				dpwp_pkg::REG_INVERSE_FOCAL: inverse_focal_q <= pwdata[23:0];
				dpwp_pkg::REG_ROT_W:         rot_w_q         <= pwdata[15:0];
				dpwp_pkg::REG_ROT_X:         rot_x_q         <= pwdata[15:0];
				dpwp_pkg::REG_ROT_Y:         rot_y_q         <= pwdata[15:0];
				dpwp_pkg::REG_ROT_Z:         rot_z_q         <= pwdata[15:0];
				dpwp_pkg::REG_SHIFT_X:       shift_q[0]      <= pwdata[23:0];
				dpwp_pkg::REG_SHIFT_Y:       shift_q[1]      <= pwdata[23:0];
				dpwp_pkg::REG_SHIFT_Z:       shift_q[2]      <= pwdata[23:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			dpwp_pkg::REG_INVERSE_FOCAL: prdata = {8'b0, inverse_focal_q};
			dpwp_pkg::REG_ROT_W:         prdata = {16'b0, rot_w_q};
			dpwp_pkg::REG_ROT_X:         prdata = {16'b0, rot_x_q};
			dpwp_pkg::REG_ROT_Y:         prdata = {16'b0, rot_y_q};
			dpwp_pkg::REG_ROT_Z:         prdata = {16'b0, rot_z_q};
			dpwp_pkg::REG_SHIFT_X:       prdata = {8'b0, shift_q[0]};
			dpwp_pkg::REG_SHIFT_Y:       prdata = {8'b0, shift_q[1]};
			dpwp_pkg::REG_SHIFT_Z:       prdata = {8'b0, shift_q[2]};
		endcase
	end

	// rotation matrix from the quaternion, two register steps
	logic signed [RP_W-1:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q, pxw_q, pyw_q, pzw_q;
	logic signed [R_W-1:0]  rot_q [9];

	always_ff @(posedge clk) begin
		pxx_q <= rot_x_q * rot_x_q;
		pyy_q <= rot_y_q * rot_y_q;
		pzz_q <= rot_z_q * rot_z_q;
		pxy_q <= rot_x_q * rot_y_q;
		pxz_q <= rot_x_q * rot_z_q;
		pyz_q <= rot_y_q * rot_z_q;
		pxw_q <= rot_x_q * rot_w_q;
		pyw_q <= rot_y_q * rot_w_q;
		pzw_q <= rot_z_q * rot_w_q;
		rot_q[0] <= R_ONE - ((R_W'(pyy_q) + R_W'(pzz_q)) <<< 1);
		rot_q[1] <= (R_W'(pxy_q) - R_W'(pzw_q)) <<< 1;
		rot_q[2] <= (R_W'(pxz_q) + R_W'(pyw_q)) <<< 1;
		rot_q[3] <= (R_W'(pxy_q) + R_W'(pzw_q)) <<< 1;
		rot_q[4] <= R_ONE - ((R_W'(pxx_q) + R_W'(pzz_q)) <<< 1);
		rot_q[5] <= (R_W'(pyz_q) - R_W'(pxw_q)) <<< 1;
		rot_q[6] <= (R_W'(pxz_q) - R_W'(pyw_q)) <<< 1;
		rot_q[7] <= (R_W'(pyz_q) + R_W'(pxw_q)) <<< 1;
		rot_q[8] <= R_ONE - ((R_W'(pxx_q) + R_W'(pyy_q)) <<< 1);
	end

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= start && !busy && (depth_mm != dpwp_pkg::NO_RETURN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: offset pixel times depth
	logic signed [DU_W-1:0]          du, dv;
	logic signed [dpwp_pkg::DEPTH_W:0] dd;
	logic signed [PU_W-1:0]          pu_s1, pv_s1;
	logic [dpwp_pkg::DEPTH_W-1:0]    d_s1, d_s2;

	assign du = $signed({1'b0, column}) - CX;
	assign dv = $signed({1'b0, row}) - CY;
	assign dd = $signed({1'b0, depth_mm});

	always_ff @(posedge clk) begin
		pu_s1 <= du * dd;
		pv_s1 <= dv * dd;
		d_s1  <= depth_mm;
	end

	// stage 2: scale by inverse focal length
	logic signed [Q_W-1:0] qu_s2, qv_s2;
	logic signed [dpwp_pkg::FOC_W:0] foc;

	assign foc = $signed({1'b0, inverse_focal_q});

	always_ff @(posedge clk) begin
		qu_s2 <= pu_s1 * foc;
		qv_s2 <= pv_s1 * foc;
		d_s2  <= d_s1;
	end

	// stage 3: round camera x, y and swap to body axes
	logic signed [Q_W-1:0] qu_rnd, qv_rnd;
	logic signed [B_W-1:0] b_s3 [3];

	assign qu_rnd = qu_s2 + (Q_HALF - Q_W'(qu_s2[Q_W-1]));
	assign qv_rnd = qv_s2 + (Q_HALF - Q_W'(qv_s2[Q_W-1]));

	always_ff @(posedge clk) begin
		b_s3[0] <= $signed({{(B_W-dpwp_pkg::DEPTH_W){1'b0}}, d_s2});
		b_s3[1] <= -$signed({qu_rnd[Q_W-1], qu_rnd[Q_W-1:FOC_SH]});
		b_s3[2] <= -$signed({qv_rnd[Q_W-1], qv_rnd[Q_W-1:FOC_SH]});
	end

	// stage 4: split matrix entries into partial products
	logic signed [PHI_W-1:0] phi_s4 [9];
	logic signed [PLO_W-1:0] plo_s4 [9];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			phi_s4[k] <= $signed(rot_q[k][R_W-1:LO_W]) * b_s3[k % 3];
			plo_s4[k] <= $signed({1'b0, rot_q[k][LO_W-1:0]}) * b_s3[k % 3];
		end
	end

	// stage 5: join partial products
	logic signed [P_W-1:0] prod_s5 [9];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			prod_s5[k] <= (P_W'(phi_s4[k]) <<< LO_W) + P_W'(plo_s4[k]);
		end
	end

	// stage 6: row sums
	logic signed [S_W-1:0] sum_s6 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sum_s6[i] <= S_W'(prod_s5[3*i]) + S_W'(prod_s5[3*i+1]) + S_W'(prod_s5[3*i+2]);
		end
	end

	// stage 7: round to millimetres, ties away from zero
	logic signed [S_W-1:0]   sum_rnd [3];
	logic signed [RND_W-1:0] rnd_s7 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_rnd[i] = sum_s6[i] + (S_HALF - S_W'(sum_s6[i][S_W-1]));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rnd_s7[i] <= sum_rnd[i][S_W-1:R_FRAC];
		end
	end

	// stage 8: translate and saturate
	logic signed [T_W-1:0] tr [3];
	dpwp_pkg::coord_t      out_s8 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tr[i] = T_W'(rnd_s7[i]) + T_W'(shift_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (tr[i] > T_W'(dpwp_pkg::OUT_MAX)) begin
				out_s8[i] <= dpwp_pkg::OUT_MAX;
			end else if (tr[i] < T_W'(dpwp_pkg::OUT_MIN)) begin
				out_s8[i] <= dpwp_pkg::OUT_MIN;
			end else begin
				out_s8[i] <= tr[i][OUT_W-1:0];
			end
		end
	end

	assign done    = v_s8;
	assign world_x = out_s8[0];
	assign world_y = out_s8[1];
	assign world_z = out_s8[2];

endmodule

@@ rtl/dpwp_check.sv @@
// Port checker for the depth pixel to world point unit, bound to the top level.
// Depends on dpwp_pkg and the top level's port names.
module dpwp_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [dpwp_pkg::DEPTH_W-1:0] depth_mm,
	input logic                         done,
	input logic                         pready
);

	a_valid_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && depth_mm != dpwp_pkg::NO_RETURN) |-> ##8 done)
		else $error("valid word did not produce done after latency");

	a_no_return_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && depth_mm == dpwp_pkg::NO_RETURN) |-> ##8 !done)
		else $error("no-return word produced a result");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, dpwp_pkg::LATENCY))
		else $error("done without a started word");

	a_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && pready)
		else $error("busy or pready out of spec");

endmodule

bind depth_pixel_to_world_point_unit dpwp_check u_dpwp_check (.*);

@@ test/dpwp_point_checker.sv @@
`timescale 1ns / 1ps
// Point checker for the depth pixel to world point unit: follows the pose registers through
// APB writes, predicts one world point per accepted pixel word that is not a no-return word
// and checks every done word. Depends on dpwp_pkg.
module dpwp_point_checker #(
	parameter int CENTER_X = 128,
	parameter int CENTER_Y = 72
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [dpwp_pkg::PIX_W-1:0]      column,
	input  logic [dpwp_pkg::PIX_W-1:0]      row,
	input  logic [dpwp_pkg::DEPTH_W-1:0]    depth_mm,
	input  logic                            done,
	input  dpwp_pkg::coord_t                world_x,
	input  dpwp_pkg::coord_t                world_y,
	input  dpwp_pkg::coord_t                world_z,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dpwp_pkg::ADDR_W-1:0]     paddr,
	input  logic [dpwp_pkg::APB_W-1:0]      pwdata,
	input  logic                            pready,
	output int                              fails,
	output int                              pending
);

	typedef struct packed {
		dpwp_pkg::coord_t x;
		dpwp_pkg::coord_t y;
		dpwp_pkg::coord_t z;
	} point_t;

	logic [dpwp_pkg::FOC_W-1:0] focal;
	dpwp_pkg::quat_t qw, qx, qy, qz;
	dpwp_pkg::coord_t sx, sy, sz;
	point_t expected_points [$];

	function automatic longint round_away(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic dpwp_pkg::coord_t clamp(longint v);
		if (v > longint'(dpwp_pkg::OUT_MAX))
			return dpwp_pkg::OUT_MAX;
		if (v < longint'(dpwp_pkg::OUT_MIN))
			return dpwp_pkg::OUT_MIN;
		return dpwp_pkg::coord_t'(v);
	endfunction

	function automatic point_t project_pixel(logic [dpwp_pkg::PIX_W-1:0] col,
			logic [dpwp_pkg::PIX_W-1:0] rw, logic [dpwp_pkg::DEPTH_W-1:0] dep);
		longint d, cam_x, cam_y, w, x, y, z, one;
		longint m [9];
		point_t p;
		d = longint'(dep);
		cam_x = round_away((longint'(col) - CENTER_X) * d * longint'(focal), dpwp_pkg::FOC_SH);
		cam_y = round_away((longint'(rw) - CENTER_Y) * d * longint'(focal), dpwp_pkg::FOC_SH);
		w = qw;
		x = qx;
		y = qy;
		z = qz;
		one = longint'(1) << dpwp_pkg::R_FRAC;
		m[0] = one - 2 * (y * y + z * z);
		m[1] = 2 * (x * y - z * w);
		m[2] = 2 * (x * z + y * w);
		m[3] = 2 * (x * y + z * w);
		m[4] = one - 2 * (x * x + z * z);
		m[5] = 2 * (y * z - x * w);
		m[6] = 2 * (x * z - y * w);
		m[7] = 2 * (y * z + x * w);
		m[8] = one - 2 * (x * x + y * y);
		// body axes are (z, -x, -y) of the camera frame
		p.x = clamp(round_away(m[0] * d - m[1] * cam_x - m[2] * cam_y, dpwp_pkg::R_FRAC) + sx);
		p.y = clamp(round_away(m[3] * d - m[4] * cam_x - m[5] * cam_y, dpwp_pkg::R_FRAC) + sy);
		p.z = clamp(round_away(m[6] * d - m[7] * cam_x - m[8] * cam_y, dpwp_pkg::R_FRAC) + sz);
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		point_t want;
		if (!arst_n) begin
			focal <= dpwp_pkg::FOCAL_RESET;
			qw <= dpwp_pkg::ROT_ONE;
			qx <= '0;
			qy <= '0;
			qz <= '0;
			sx <= '0;
			sy <= '0;
			sz <= '0;
			expected_points.delete();
			fails = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_points.size() == 0) begin
					$error("done word with no pixel pending: %0d %0d %0d",
						world_x, world_y, world_z);
					fails++;
				end else begin
					want = expected_points.pop_front();
					if (want.x !== world_x) begin
						$error("world_x: expected %0d, got %0d", want.x, world_x);
						fails++;
					end
					if (want.y !== world_y) begin
						$error("world_y: expected %0d, got %0d", want.y, world_y);
						fails++;
					end
					if (want.z !== world_z) begin
						$error("world_z: expected %0d, got %0d", want.z, world_z);
						fails++;
					end
				end
			end
			if (start && !busy && depth_mm != dpwp_pkg::NO_RETURN)
				expected_points.insert(expected_points.size(),
					project_pixel(column, row, depth_mm));
			if (psel && penable && pwrite && pready) begin
				case (paddr[dpwp_pkg::ADDR_W-1:2])
					dpwp_pkg::REG_INVERSE_FOCAL: focal <= pwdata[dpwp_pkg::FOC_W-1:0];
					dpwp_pkg::REG_ROT_W:         qw <= pwdata[dpwp_pkg::ROT_W-1:0];
					dpwp_pkg::REG_ROT_X:         qx <= pwdata[dpwp_pkg::ROT_W-1:0];
					dpwp_pkg::REG_ROT_Y:         qy <= pwdata[dpwp_pkg::ROT_W-1:0];
					dpwp_pkg::REG_ROT_Z:         qz <= pwdata[dpwp_pkg::ROT_W-1:0];
					dpwp_pkg::REG_SHIFT_X:       sx <= pwdata[dpwp_pkg::OUT_W-1:0];
					dpwp_pkg::REG_SHIFT_Y:       sy <= pwdata[dpwp_pkg::OUT_W-1:0];
					dpwp_pkg::REG_SHIFT_Z:       sz <= pwdata[dpwp_pkg::OUT_W-1:0];
					default: ;
				endcase
			end
			pending <= expected_points.size();
		end
	end

endmodule

@@ test/tb_depth_pixel_to_world_point_unit.sv @@
`timescale 1ns / 1ps
// Top testbench for the depth pixel to world point unit: drives pixel words and pose writes,
// runs a watchdog and prints the verdict. Depends on dpwp_pkg, the unit and dpwp_point_checker.
module tb_depth_pixel_to_world_point_unit;

	localparam int PIX_W = dpwp_pkg::PIX_W;
	localparam int DEPTH_W = dpwp_pkg::DEPTH_W;
	localparam int APB_W = dpwp_pkg::APB_W;
	localparam int CX = 128;
	localparam int CY = 72;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 100;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [PIX_W-1:0] column = '0;
	logic [PIX_W-1:0] row = '0;
	logic [DEPTH_W-1:0] depth_mm = '0;
	logic done;
	dpwp_pkg::coord_t world_x, world_y, world_z;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [dpwp_pkg::ADDR_W-1:0] paddr = '0;
	logic [APB_W-1:0] pwdata = '0;
	logic [APB_W-1:0] prdata;
	logic pready;

	int fails;
	int pending;
	int quiet = 0;
	int gap_pct = 0;

	depth_pixel_to_world_point_unit #(.CENTER_X(CX), .CENTER_Y(CY)) dut (.*);

	dpwp_point_checker #(.CENTER_X(CX), .CENTER_Y(CY)) point_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.column(column), .row(row), .depth_mm(depth_mm),
		.done(done), .world_x(world_x), .world_y(world_y), .world_z(world_z),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite && pready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("depth_pixel_to_world_point_unit verification failed");
			$finish;
		end
	end

	task automatic idle_gap(input int n);
		start <= 1'b0;
		column <= PIX_W'($urandom());
		row <= PIX_W'($urandom());
		depth_mm <= DEPTH_W'($urandom());
		repeat (n) @(posedge clk);
	endtask

	task automatic drive_pixel(input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] r,
			input logic [DEPTH_W-1:0] d);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
			idle_gap($urandom_range(1, 3));
		start <= 1'b1;
		column <= c;
		row <= r;
		depth_mm <= d;
		do @(posedge clk); while (busy);
	endtask

	// hold off until every point is out, then let the pipeline empty
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (dpwp_pkg::LATENCY + 2) @(posedge clk);
	endtask

	function automatic logic [APB_W-1:0] field(input int v, input int w);
		logic [APB_W-1:0] junk;
		junk = $urandom_range(0, 1) ? APB_W'($urandom()) : '0;
		return (junk << w) | (APB_W'(v) & ((APB_W'(1) << w) - 1));
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [APB_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic load_pose(input int f, input int w, input int x, input int y, input int z,
			input int sx, input int sy, input int sz);
		write_reg(dpwp_pkg::REG_INVERSE_FOCAL, field(f, dpwp_pkg::FOC_W));
		write_reg(dpwp_pkg::REG_ROT_W, field(w, dpwp_pkg::ROT_W));
		write_reg(dpwp_pkg::REG_ROT_X, field(x, dpwp_pkg::ROT_W));
		write_reg(dpwp_pkg::REG_ROT_Y, field(y, dpwp_pkg::ROT_W));
		write_reg(dpwp_pkg::REG_ROT_Z, field(z, dpwp_pkg::ROT_W));
		write_reg(dpwp_pkg::REG_SHIFT_X, field(sx, dpwp_pkg::OUT_W));
		write_reg(dpwp_pkg::REG_SHIFT_Y, field(sy, dpwp_pkg::OUT_W));
		write_reg(dpwp_pkg::REG_SHIFT_Z, field(sz, dpwp_pkg::OUT_W));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		repeat (dpwp_pkg::LATENCY) @(posedge clk);
	endtask

	task automatic pick_pose();
		int q [4];
		int f, i;
		int s [3];
		case ($urandom_range(0, 3))
			0: f = 156206 + int'($urandom_range(0, 40000)) - 20000;
			1: f = $urandom_range(1, 400000);
			2: f = $urandom_range(0, 32'hFFFFFF);
			default: f = $urandom_range(0, 1) ? 32'hFFFFFF : 0;
		endcase
		case ($urandom_range(0, 2))
			0: begin
				q = '{16384, 0, 0, 0};
				case ($urandom_range(0, 2))
					0: ;
					1: begin
						q[0] = 11585;
						q[$urandom_range(1, 3)] = 11585;
					end
					default: q = '{8192, 8192, 8192, 8192};
				endcase
				for (i = 0; i < 4; i++)
					if ($urandom_range(0, 1))
						q[i] = -q[i];
			end
			1: for (i = 0; i < 4; i++)
				q[i] = int'($urandom_range(0, 32768)) - 16384;
			default: for (i = 0; i < 4; i++)
				q[i] = $urandom_range(0, 65535);
		endcase
		for (i = 0; i < 3; i++)
			s[i] = $urandom_range(0, 2) == 0 ? int'($urandom_range(0, 32'hFFFFFF))
				: int'($urandom_range(0, 40000)) - 20000;
		load_pose(f, q[0], q[1], q[2], q[3], s[0], s[1], s[2]);
	endtask

	task automatic run_corners();
		drive_pixel('0, '0, '0);
		drive_pixel(10'd1023, 10'd1023, 16'd65534);
		drive_pixel(PIX_W'(CX), PIX_W'(CY), 16'd1234);
		drive_pixel('0, 10'd1023, dpwp_pkg::NO_RETURN);
		drive_pixel(10'd1023, '0, 16'd1);
		drive_pixel('0, '0, 16'd65534);
		drive_pixel(10'd512, 10'd300, '0);
		drive_pixel(10'd1023, 10'd1023, dpwp_pkg::NO_RETURN);
	endtask

	task automatic drive_random_pixel();
		int sel;
		logic [PIX_W-1:0] c, r;
		logic [DEPTH_W-1:0] d;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			d = dpwp_pkg::NO_RETURN;
		else if (sel < 14)
			d = '0;
		else if (sel < 18)
			d = dpwp_pkg::NO_RETURN - 1'b1;
		else if (sel < 55)
			d = DEPTH_W'($urandom_range(1, 8000));
		else
			d = DEPTH_W'($urandom_range(0, 65534));
		if ($urandom_range(0, 4) == 0) begin
			c = PIX_W'(CX + $urandom_range(0, 16) - 8);
			r = PIX_W'(CY + $urandom_range(0, 16) - 8);
		end else begin
			c = PIX_W'($urandom_range(0, 1023));
			r = PIX_W'($urandom_range(0, 1023));
		end
		drive_pixel(c, r, d);
	endtask

	initial begin : stimulus
		int ph, k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 25;
		run_corners();
		settle();
		load_pose(0, -32768, 32767, -32768, 32767, int'(dpwp_pkg::OUT_MAX),
			int'(dpwp_pkg::OUT_MIN), int'(dpwp_pkg::OUT_MAX));
		run_corners();
		settle();
		load_pose(32'hFFFFFF, 16384, 0, 0, 0, int'(dpwp_pkg::OUT_MIN), int'(dpwp_pkg::OUT_MAX), 0);
		run_corners();
		settle();
		for (ph = 0; ph < PHASES; ph++) begin
			pick_pose();
			gap_pct = (ph == PHASES - 1) ? 0 : $urandom_range(0, 2) * 20;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 1 && k == PHASE_ITEMS / 2)
					settle();
				drive_random_pixel();
			end
			settle();
		end
		if (fails == 0)
			$display("depth_pixel_to_world_point_unit verification clean");
		else
			$display("depth_pixel_to_world_point_unit verification failed");
		$finish;
	end

endmodule
